/* hdl/crc_frame_checker_core_assert.svh */
// ---------------------------------------------------------------------------
// crc_frame_checker_core assertion macros
// Concurrent check helpers for the frame checker; empty when SYNTH is set.
// ---------------------------------------------------------------------------
`ifndef CRC_FRAME_CHECKER_CORE_ASSERT_SVH
`define CRC_FRAME_CHECKER_CORE_ASSERT_SVH

`ifndef SYNTH

// Check that prop holds at every rising clock edge outside reset.
`define CFC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("crc_frame_checker_core: assertion failed");

// Check that cond is never true outside reset.
`define CFC_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("crc_frame_checker_core: forbidden condition seen");

`else

`define CFC_ASSERT(lbl, clk, rstn, prop)
`define CFC_ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

/* hdl/crc_fc_pkg.sv */
// ---------------------------------------------------------------------------
// crc_fc_pkg
// Types, constants and the byte-wide CRC16 update for the frame checker.
// ---------------------------------------------------------------------------
package crc_fc_pkg;

  // Frame layout
  localparam int unsigned SofBytes  = 4;
  localparam int unsigned CrcLoPos  = 4;
  localparam int unsigned CrcHiPos  = 5;
  localparam int unsigned LenPos    = 6;
  localparam int unsigned HdrBytes  = 7;

  // Result queue depth: room for one waiting beat plus a two-beat byte
  localparam int unsigned QDepth    = 3;

  // Register reset values
  localparam logic [31:0] SofAReset    = 32'hA1B1_C1D1;
  localparam logic [31:0] SofBReset    = 32'hA2B2_C2D2;
  localparam logic [15:0] CrcPolyReset = 16'h1021;
  localparam logic [15:0] CrcSeedReset = 16'hFFFF;

  typedef enum logic [1:0] {
    REG_SOF_A    = 2'd0,
    REG_SOF_B    = 2'd1,
    REG_CRC_POLY = 2'd2,
    REG_CRC_SEED = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    RES_PAYLOAD = 1'b0,
    RES_STATUS  = 1'b1
  } result_kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_SOF = 2'd1,
    ST_CRC_ERR = 2'd2,
    ST_LEN_ERR = 2'd3
  } frame_status_e;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_A    = 2'd1,
    KIND_B    = 2'd2
  } frame_kind_e;

  typedef struct packed {
    result_kind_e  kind;
    logic [7:0]    payload_byte;
    logic [7:0]    payload_pos;
    frame_status_e status;
    frame_kind_e   frame_kind;
    logic [7:0]    payload_count;
    logic          final_flag;
  } result_t;

  // Results raised by one accepted byte, payload beat first
  typedef struct packed {
    logic [1:0] num;
    result_t    item0;
    result_t    item1;
  } q_push_t;

  // Fold one byte into the CRC, MSB first, no reflection
  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] data,
                                             logic [15:0] poly);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ poly) : (c << 1);
    end
    return c;
  endfunction

endpackage

/* hdl/crc_fc_result_queue.sv */
// ---------------------------------------------------------------------------
// crc_fc_result_queue
// Three-entry shift queue of result beats; takes up to two beats per cycle.
// ---------------------------------------------------------------------------
module crc_fc_result_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  crc_fc_pkg::q_push_t push_i,
  input  logic                pop_i,
  output logic                room_o,
  output logic                valid_o,
  output crc_fc_pkg::result_t head_o
);

  crc_fc_pkg::result_t entry_q [crc_fc_pkg::QDepth];
  crc_fc_pkg::result_t entry_d [crc_fc_pkg::QDepth];
  logic [1:0]          count_q, count_d;
  logic [1:0]          base;

  assign valid_o = (count_q != 2'd0);
  assign head_o  = entry_q[0];
  // Room for a worst-case two-beat push regardless of the pop this cycle
  assign room_o  = (count_q <= 2'd1);

  always_comb begin
    base    = count_q - {1'b0, pop_i};
    count_d = base + push_i.num;
    for (int k = 0; k < crc_fc_pkg::QDepth; k++) begin
      if (pop_i && (k < crc_fc_pkg::QDepth - 1)) begin
        entry_d[k] = entry_q[k + 1];
      end else begin
        entry_d[k] = entry_q[k];
      end
      if ((push_i.num != 2'd0) && (2'(k) == base)) begin
        entry_d[k] = push_i.item0;
      end
      if ((push_i.num == 2'd2) && (2'(k) == base + 2'd1)) begin
        entry_d[k] = push_i.item1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

/* hdl/crc_frame_checker_core.sv */
// ---------------------------------------------------------------------------
// crc_frame_checker_core
// Byte-serial start-pattern / length / CRC16 frame checker.
// ---------------------------------------------------------------------------
// Feed the bytes of one received chunk, one per beat, with chunk_end_i high
// on the last. The chunk is read as a 4-byte start pattern (kind a or b),
// CRC16 low and high byte, a length byte and the payload; bytes past the
// payload are ignored. Each payload byte is sent out as a tentative beat
// (result_kind 0) as soon as it arrives while a start pattern still matches;
// the last byte of the chunk raises a status beat (result_kind 1, final_flag
// 1) that says whether the payload stands. The CRC is MSB-first with no
// reflection and no final xor, seeded from crc_seed at each chunk start and
// run over the length byte and payload. Rate: one byte per clock while the
// queue has room. The byte is worked in the cycle it is accepted and its
// beats are registered in a three-entry result queue ahead of the output.
// A byte that carries both the last payload byte and chunk_end gives two
// beats. The input stalls whenever the queue holds two or more beats: after
// a two-beat byte even with the output side always ready, and while a slow
// output side leaves them there. Write configuration only while idle.
// ---------------------------------------------------------------------------
module crc_frame_checker_core #(
  parameter int unsigned MAX_CHUNK_BYTES = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  // byte input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        chunk_end_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        result_kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [7:0]  payload_pos_o,
  output logic [1:0]  frame_status_o,
  output logic [1:0]  frame_kind_o,
  output logic [7:0]  payload_count_o,
  output logic        final_flag_o
);

  localparam int unsigned IdxW = $clog2(MAX_CHUNK_BYTES + 1);
  localparam logic [IdxW-1:0] IdxMax = IdxW'(MAX_CHUNK_BYTES);

  // Configuration registers
  logic [31:0] sof_a_q, sof_b_q;
  logic [15:0] crc_poly_q, crc_seed_q;

  // Frame state
  logic [IdxW-1:0] idx_q, idx_d;
  logic            match_a_q, match_a_d;
  logic            match_b_q, match_b_d;
  logic [15:0]     rcrc_q, rcrc_d;
  logic [7:0]      len_q, len_d;
  logic [15:0]     crc_q, crc_d;

  logic                in_acc;
  logic                payload_hit;
  logic [IdxW-1:0]     pay_pos;
  logic [IdxW:0]       n_bytes;
  logic [31:0]         sof_a_sh, sof_b_sh;
  crc_fc_pkg::result_t pay_res, stat_res, head;
  crc_fc_pkg::q_push_t q_push;
  logic                q_room;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = q_room;
  assign in_acc      = in_valid_i && in_ready_o;

  // Config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sof_a_q    <= crc_fc_pkg::SofAReset;
      sof_b_q    <= crc_fc_pkg::SofBReset;
      crc_poly_q <= crc_fc_pkg::CrcPolyReset;
      crc_seed_q <= crc_fc_pkg::CrcSeedReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (crc_fc_pkg::cfg_reg_e'(cfg_index_i))
        crc_fc_pkg::REG_SOF_A:    sof_a_q    <= cfg_data_i;
        crc_fc_pkg::REG_SOF_B:    sof_b_q    <= cfg_data_i;
        crc_fc_pkg::REG_CRC_POLY: crc_poly_q <= cfg_data_i[15:0];
        crc_fc_pkg::REG_CRC_SEED: crc_seed_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Pick the pattern byte that lines up with the current header position
  assign sof_a_sh = sof_a_q >> {idx_q[1:0], 3'b000};
  assign sof_b_sh = sof_b_q >> {idx_q[1:0], 3'b000};
  assign pay_pos  = idx_q - IdxW'(crc_fc_pkg::HdrBytes);
  assign n_bytes  = {1'b0, idx_q} + (IdxW+1)'(1);

  // Per-byte work: advance frame state and build this byte's beats
  always_comb begin
    match_a_d   = match_a_q;
    match_b_d   = match_b_q;
    rcrc_d      = rcrc_q;
    len_d       = len_q;
    // Load the seed at chunk start; it is only folded from the length byte on
    crc_d       = (idx_q == '0) ? crc_seed_q : crc_q;
    payload_hit = 1'b0;

    if (idx_q < IdxW'(crc_fc_pkg::SofBytes)) begin
      if (sof_a_sh[7:0] != rx_byte_i) match_a_d = 1'b0;
      if (sof_b_sh[7:0] != rx_byte_i) match_b_d = 1'b0;
    end else if (idx_q == IdxW'(crc_fc_pkg::CrcLoPos)) begin
      rcrc_d = {8'h00, rx_byte_i};
    end else if (idx_q == IdxW'(crc_fc_pkg::CrcHiPos)) begin
      rcrc_d = {rx_byte_i, rcrc_q[7:0]};
    end else if (idx_q == IdxW'(crc_fc_pkg::LenPos)) begin
      len_d = rx_byte_i;
      crc_d = crc_fc_pkg::crc16_byte(crc_d, rx_byte_i, crc_poly_q);
    end else if (pay_pos < IdxW'(len_q)) begin
      crc_d       = crc_fc_pkg::crc16_byte(crc_d, rx_byte_i, crc_poly_q);
      payload_hit = match_a_q || match_b_q;
    end

    idx_d = (idx_q != IdxMax) ? idx_q + IdxW'(1) : idx_q;

    pay_res               = '0;
    pay_res.kind          = crc_fc_pkg::RES_PAYLOAD;
    pay_res.payload_byte  = rx_byte_i;
    pay_res.payload_pos   = pay_pos[7:0];

    // Status priority: short chunk, start pattern, length, CRC
    stat_res            = '0;
    stat_res.kind       = crc_fc_pkg::RES_STATUS;
    stat_res.final_flag = 1'b1;
    if (n_bytes < (IdxW+1)'(crc_fc_pkg::HdrBytes)) begin
      stat_res.status = crc_fc_pkg::ST_LEN_ERR;
    end else begin
      stat_res.payload_count = len_d;
      if (match_a_d) begin
        stat_res.frame_kind = crc_fc_pkg::KIND_A;
      end else if (match_b_d) begin
        stat_res.frame_kind = crc_fc_pkg::KIND_B;
      end
      if (!match_a_d && !match_b_d) begin
        stat_res.status = crc_fc_pkg::ST_BAD_SOF;
      end else if ((IdxW+1)'(crc_fc_pkg::HdrBytes) + (IdxW+1)'(len_d) > n_bytes) begin
        stat_res.status = crc_fc_pkg::ST_LEN_ERR;
      end else if (crc_d != rcrc_d) begin
        stat_res.status = crc_fc_pkg::ST_CRC_ERR;
      end else begin
        stat_res.status = crc_fc_pkg::ST_OK;
      end
    end

    // Payload beat goes first when both land on the same byte
    q_push.num   = 2'b00;
    q_push.item0 = payload_hit ? pay_res : stat_res;
    q_push.item1 = stat_res;
    if (in_acc) begin
      q_push.num = {1'b0, payload_hit} + {1'b0, chunk_end_i};
    end
  end

  // Frame state register; drop everything after the status beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      match_a_q <= 1'b1;
      match_b_q <= 1'b1;
      rcrc_q    <= '0;
      len_q     <= '0;
      crc_q     <= crc_fc_pkg::CrcSeedReset;
    end else if (in_acc) begin
      crc_q <= crc_d;
      if (chunk_end_i) begin
        idx_q     <= '0;
        match_a_q <= 1'b1;
        match_b_q <= 1'b1;
        rcrc_q    <= '0;
        len_q     <= '0;
      end else begin
        idx_q     <= idx_d;
        match_a_q <= match_a_d;
        match_b_q <= match_b_d;
        rcrc_q    <= rcrc_d;
        len_q     <= len_d;
      end
    end
  end

  crc_fc_result_queue u_result_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .pop_i   (out_valid_o && out_ready_i),
    .room_o  (q_room),
    .valid_o (out_valid_o),
    .head_o  (head)
  );

  assign result_kind_o   = head.kind;
  assign payload_byte_o  = head.payload_byte;
  assign payload_pos_o   = head.payload_pos;
  assign frame_status_o  = head.status;
  assign frame_kind_o    = head.frame_kind;
  assign payload_count_o = head.payload_count;
  assign final_flag_o    = head.final_flag;

`include "crc_frame_checker_core_assert.svh"

  // Chunk end restarts the frame
  `CFC_ASSERT(a_end_clears, clk_i, rst_ni, (in_acc && chunk_end_i) |=> (idx_q == '0))
  // A status beat is always waiting right after a chunk end
  `CFC_ASSERT(a_end_gives_beat, clk_i, rst_ni, (in_acc && chunk_end_i) |=> out_valid_o)
  // No payload beat once both start patterns have failed
  `CFC_ASSERT_NEVER(a_no_pay_bad_sof, clk_i, rst_ni, payload_hit && !match_a_q && !match_b_q)
  // Byte index stays within its saturation bound
  `CFC_ASSERT(a_idx_bound, clk_i, rst_ni, idx_q <= IdxMax)

endmodule

/* sim/tb_top.sv */
// ---------------------------------------------------------------------------
// tb_top: frame checker core testbench
// Feeds received chunks one byte per beat through the input handshake and
// checks every result beat against a built-in frame checker predictor. It
// covers short, truncated, broken-start, bad-CRC, trailing-byte and over-long
// chunks under several register settings and idle/stall patterns.
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Chunk size cap of the instance; bytes past it are ignored by the block.
  localparam int unsigned ChunkCap     = 512;
  localparam int          NumPhases    = 8;
  localparam int          RandPerPhase = 175;
  // A beat is registered in the result queue after its byte; add a settle wait.
  localparam int          SettleCycles = 4;
  // Longest legal quiet stretch is a settle wait or a run of random stalls,
  // both far below this.
  localparam int          QuietLimit   = 4000;

  // How the start pattern of a generated frame is chosen.
  typedef enum int {
    SOF_USE_A,
    SOF_USE_B,
    SOF_RANDOM,
    SOF_A_BROKEN
  } sof_pick_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } rx_beat_t;

  typedef struct packed {
    crc_fc_pkg::cfg_reg_e idx;
    logic [31:0]          val;
  } reg_write_t;

  // -------------------------------------------------------------------------
  // DUT ports; every input starts at a known value
  // -------------------------------------------------------------------------
  logic        clk_i;
  logic        rst_ni       = 1'b0;
  logic        cfg_valid_i  = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i  = '0;
  logic [31:0] cfg_data_i   = '0;
  logic        in_valid_i   = 1'b0;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i    = '0;
  logic        chunk_end_i  = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i  = 1'b0;
  logic        result_kind_o;
  logic [7:0]  payload_byte_o;
  logic [7:0]  payload_pos_o;
  logic [1:0]  frame_status_o;
  logic [1:0]  frame_kind_o;
  logic [7:0]  payload_count_o;
  logic        final_flag_o;

  crc_frame_checker_core #(
    .MAX_CHUNK_BYTES(ChunkCap)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .rx_byte_i      (rx_byte_i),
    .chunk_end_i    (chunk_end_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_kind_o  (result_kind_o),
    .payload_byte_o (payload_byte_o),
    .payload_pos_o  (payload_pos_o),
    .frame_status_o (frame_status_o),
    .frame_kind_o   (frame_kind_o),
    .payload_count_o(payload_count_o),
    .final_flag_o   (final_flag_o)
  );

  // -------------------------------------------------------------------------
  // Register copies, as the block should hold them
  // -------------------------------------------------------------------------
  logic [31:0] cfg_sof_a = crc_fc_pkg::SofAReset;
  logic [31:0] cfg_sof_b = crc_fc_pkg::SofBReset;
  logic [15:0] cfg_poly  = crc_fc_pkg::CrcPolyReset;
  logic [15:0] cfg_seed  = crc_fc_pkg::CrcSeedReset;

  // Per-chunk checker state
  int unsigned fr_index   = 0;
  logic        fr_match_a = 1'b1;
  logic        fr_match_b = 1'b1;
  logic [15:0] fr_rx_crc  = '0;
  logic [7:0]  fr_len     = '0;
  logic [15:0] fr_crc     = crc_fc_pkg::CrcSeedReset;

  // Stimulus and expectation stores
  rx_beat_t            byte_backlog[$];
  reg_write_t          reg_writes[$];
  crc_fc_pkg::result_t beats_due[$];

  int bytes_queued  = 0;
  int bytes_taken   = 0;
  int regs_queued   = 0;
  int regs_applied  = 0;
  int beats_seen    = 0;
  int miss_count    = 0;
  int quiet_cycles  = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // -------------------------------------------------------------------------
  // Clock
  // -------------------------------------------------------------------------
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // -------------------------------------------------------------------------
  // CRC16, MSB first: shift one data bit at a time into the register top.
  // -------------------------------------------------------------------------
  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int k = 7; k >= 0; k--) begin
      fb = c[15] ^ b[k];
      c  = {c[14:0], 1'b0};
      if (fb) c = c ^ cfg_poly;
    end
    return c;
  endfunction

  // -------------------------------------------------------------------------
  // Advance the checker state by one accepted byte and queue the beats that
  // byte must produce: a payload beat first, then the status beat on the
  // chunk's last byte.
  // -------------------------------------------------------------------------
  task automatic judge_rx_byte(input logic [7:0] b, input logic last);
    int unsigned         pos;
    int unsigned         seen_bytes;
    crc_fc_pkg::result_t r;
    pos        = fr_index;
    seen_bytes = pos + 1;
    if (pos == 0) fr_crc = cfg_seed;

    if (pos < crc_fc_pkg::SofBytes) begin
      // Drop a pattern as soon as one of its bytes disagrees.
      if (cfg_sof_a[8*pos +: 8] != b) fr_match_a = 1'b0;
      if (cfg_sof_b[8*pos +: 8] != b) fr_match_b = 1'b0;
    end else if (pos == crc_fc_pkg::CrcLoPos) begin
      fr_rx_crc = {8'h00, b};
    end else if (pos == crc_fc_pkg::CrcHiPos) begin
      fr_rx_crc[15:8] = b;
    end else if (pos == crc_fc_pkg::LenPos) begin
      fr_len = b;
      fr_crc = crc16_step(fr_crc, b);
    end else if (pos - crc_fc_pkg::HdrBytes < fr_len) begin
      fr_crc = crc16_step(fr_crc, b);
      // Pass payload on only while some start pattern still holds.
      if (fr_match_a || fr_match_b) begin
        r              = '0;
        r.kind         = crc_fc_pkg::RES_PAYLOAD;
        r.payload_byte = b;
        r.payload_pos  = 8'(pos - crc_fc_pkg::HdrBytes);
        r.status       = crc_fc_pkg::ST_OK;
        r.frame_kind   = crc_fc_pkg::KIND_NONE;
        beats_due.push_back(r);
      end
    end

    // Saturate the index so over-long chunks stop advancing.
    if (fr_index < ChunkCap) fr_index++;

    if (last) begin
      r            = '0;
      r.kind       = crc_fc_pkg::RES_STATUS;
      r.final_flag = 1'b1;
      r.status     = crc_fc_pkg::ST_OK;
      r.frame_kind = crc_fc_pkg::KIND_NONE;
      if (seen_bytes < crc_fc_pkg::HdrBytes) begin
        // Too short to hold a header: no length byte to report.
        r.status = crc_fc_pkg::ST_LEN_ERR;
      end else begin
        r.payload_count = fr_len;
        if (fr_match_a) r.frame_kind = crc_fc_pkg::KIND_A;
        else if (fr_match_b) r.frame_kind = crc_fc_pkg::KIND_B;
        if (r.frame_kind == crc_fc_pkg::KIND_NONE) r.status = crc_fc_pkg::ST_BAD_SOF;
        else if (crc_fc_pkg::HdrBytes + fr_len > seen_bytes)
          r.status = crc_fc_pkg::ST_LEN_ERR;
        else if (fr_crc != fr_rx_crc) r.status = crc_fc_pkg::ST_CRC_ERR;
        else r.status = crc_fc_pkg::ST_OK;
      end
      beats_due.push_back(r);
      // Clear for the next chunk.
      fr_index   = 0;
      fr_match_a = 1'b1;
      fr_match_b = 1'b1;
      fr_rx_crc  = '0;
      fr_len     = '0;
      fr_crc     = cfg_seed;
    end
  endtask

  task automatic report_miss(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    miss_count++;
    $display("[%0t] beat %0d: %s got 0x%0h, expected 0x%0h",
             $time, beats_seen, what, got, want);
  endtask

  // -------------------------------------------------------------------------
  // Stimulus builders
  // -------------------------------------------------------------------------
  task automatic queue_byte(input logic [7:0] d, input logic last);
    rx_beat_t nb;
    nb.data = d;
    nb.last = last;
    byte_backlog.push_back(nb);
    bytes_queued++;
  endtask

  task automatic queue_reg(input crc_fc_pkg::cfg_reg_e idx, input logic [31:0] val);
    reg_write_t w;
    w.idx = idx;
    w.val = val;
    reg_writes.push_back(w);
    regs_queued++;
  endtask

  // Build one chunk: start pattern, CRC, length, payload. A positive extra
  // appends trailing bytes, a negative one cuts the chunk short (never below
  // one byte).
  task automatic queue_frame(input sof_pick_e pick, input int len, input bit crc_good,
                             input int extra);
    logic [7:0]  fb[$];
    logic [7:0]  pay[$];
    logic [31:0] sof;
    logic [15:0] c;
    logic [7:0]  pb;
    int          total;
    int          k;
    case (pick)
      SOF_USE_A:  sof = cfg_sof_a;
      SOF_USE_B:  sof = cfg_sof_b;
      SOF_RANDOM: sof = $urandom;
      default: begin
        // Corrupt one byte of pattern a.
        k   = $urandom_range(3);
        sof = cfg_sof_a ^ (32'($urandom_range(1, 255)) << (8 * k));
      end
    endcase

    c = crc16_step(cfg_seed, 8'(len));
    for (k = 0; k < len; k++) begin
      pb = 8'($urandom_range(255));
      pay.push_back(pb);
      c = crc16_step(c, pb);
    end
    if (!crc_good) c = c ^ 16'($urandom_range(1, 65535));

    for (k = 0; k < crc_fc_pkg::SofBytes; k++) fb.push_back(sof[8*k +: 8]);
    fb.push_back(c[7:0]);
    fb.push_back(c[15:8]);
    fb.push_back(8'(len));
    for (k = 0; k < len; k++) fb.push_back(pay[k]);

    total = crc_fc_pkg::HdrBytes + len + extra;
    if (total < 1) total = 1;
    while (fb.size() < total) fb.push_back(8'($urandom_range(255)));
    for (k = 0; k < total; k++) queue_byte(fb[k], k == total - 1);
  endtask

  // -------------------------------------------------------------------------
  // Byte driver: present the next backlog byte when the channel is free and
  // the sender is not idling; hold it until accepted.
  // -------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : drive_bytes
    logic     took;
    rx_beat_t nb;
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      rx_byte_i   <= '0;
      chunk_end_i <= 1'b0;
    end else begin
      took = in_valid_i && in_ready_o;
      if (took) begin
        judge_rx_byte(rx_byte_i, chunk_end_i);
        bytes_taken++;
      end
      if (took || !in_valid_i) begin
        if (byte_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nb = byte_backlog.pop_front();
          in_valid_i  <= 1'b1;
          rx_byte_i   <= nb.data;
          chunk_end_i <= nb.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Register write driver; update the register copies on acceptance.
  // -------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : drive_regs
    logic       took;
    reg_write_t w;
    if (!rst_ni) begin
      cfg_valid_i <= 1'b0;
      cfg_index_i <= '0;
      cfg_data_i  <= '0;
    end else begin
      took = cfg_valid_i && cfg_ready_o;
      if (took) begin
        case (cfg_index_i)
          crc_fc_pkg::REG_SOF_A:    cfg_sof_a = cfg_data_i;
          crc_fc_pkg::REG_SOF_B:    cfg_sof_b = cfg_data_i;
          crc_fc_pkg::REG_CRC_POLY: cfg_poly  = cfg_data_i[15:0];
          crc_fc_pkg::REG_CRC_SEED: cfg_seed  = cfg_data_i[15:0];
          default: ;
        endcase
        regs_applied++;
      end
      if (took || !cfg_valid_i) begin
        if (reg_writes.size() != 0) begin
          w = reg_writes.pop_front();
          cfg_valid_i <= 1'b1;
          cfg_index_i <= w.idx;
          cfg_data_i  <= w.val;
        end else begin
          cfg_valid_i <= 1'b0;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Result monitor: compare each accepted beat with the oldest expectation,
  // field by field; stall the output side at random.
  // -------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : watch_beats
    crc_fc_pkg::result_t seen;
    crc_fc_pkg::result_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        seen.kind          = crc_fc_pkg::result_kind_e'(result_kind_o);
        seen.payload_byte  = payload_byte_o;
        seen.payload_pos   = payload_pos_o;
        seen.status        = crc_fc_pkg::frame_status_e'(frame_status_o);
        seen.frame_kind    = crc_fc_pkg::frame_kind_e'(frame_kind_o);
        seen.payload_count = payload_count_o;
        seen.final_flag    = final_flag_o;
        if (beats_due.size() == 0) begin
          report_miss("unexpected beat", 32'(seen), '0);
        end else begin
          want = beats_due.pop_front();
          if (seen.kind !== want.kind)
            report_miss("result_kind", 32'(seen.kind), 32'(want.kind));
          if (seen.payload_byte !== want.payload_byte)
            report_miss("payload_byte", 32'(seen.payload_byte), 32'(want.payload_byte));
          if (seen.payload_pos !== want.payload_pos)
            report_miss("payload_pos", 32'(seen.payload_pos), 32'(want.payload_pos));
          if (seen.status !== want.status)
            report_miss("frame_status", 32'(seen.status), 32'(want.status));
          if (seen.frame_kind !== want.frame_kind)
            report_miss("frame_kind", 32'(seen.frame_kind), 32'(want.frame_kind));
          if (seen.payload_count !== want.payload_count)
            report_miss("payload_count", 32'(seen.payload_count),
                        32'(want.payload_count));
          if (seen.final_flag !== want.final_flag)
            report_miss("final_flag", 32'(seen.final_flag), 32'(want.final_flag));
        end
        beats_seen++;
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // -------------------------------------------------------------------------
  // Watchdog: end the run if no channel moves a beat for too long.
  // -------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else if (quiet_cycles >= QuietLimit) begin
        $display("[%0t] no handshake for %0d cycles", $time, QuietLimit);
        $display("status: fail");
        $finish;
      end else begin
        quiet_cycles++;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Phase sequencer: reset once, then for each phase pick the idle pattern,
  // load registers while the block is idle, queue the chunks and drain.
  // -------------------------------------------------------------------------
  initial begin : run_phases
    int          ph;
    int          k;
    int          n;
    int          r;
    int          len;
    int          extra;
    int          start_bytes;
    sof_pick_e   pick;
    logic [31:0] a;
    logic [31:0] b;
    logic [15:0] p;
    logic [15:0] s;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (ph = 0; ph < NumPhases; ph++) begin
      // Idle pattern: none, sender 60%, receiver 60%, both 23%.
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase

      // Phase 0 runs on reset values; later phases rewrite every register.
      if (ph > 0) begin
        case (ph)
          1: begin a = '0; b = '0; p = '0; s = '0; end
          2: begin a = '1; b = 32'hFFFF_FF00; p = '1; s = '1; end
          NumPhases - 1: begin
            a = crc_fc_pkg::SofAReset;
            b = crc_fc_pkg::SofBReset;
            p = crc_fc_pkg::CrcPolyReset;
            s = crc_fc_pkg::CrcSeedReset;
          end
          default: begin
            a = $urandom;
            // One phase gives the two patterns a common prefix.
            b = (ph == 5) ? {8'($urandom), a[23:0]} : $urandom;
            p = 16'($urandom);
            s = 16'($urandom);
          end
        endcase
        queue_reg(crc_fc_pkg::REG_SOF_A, a);
        queue_reg(crc_fc_pkg::REG_SOF_B, b);
        queue_reg(crc_fc_pkg::REG_CRC_POLY, {16'h0000, p});
        queue_reg(crc_fc_pkg::REG_CRC_SEED, {16'h0000, s});
        while (regs_applied != regs_queued) @(posedge clk_i);
      end

      if (ph == 0) begin
        // Directed: one-byte chunk, good empty frame of kind a, kind b frame
        // with a bad CRC whose last payload byte ends the chunk, and a chunk
        // one byte short of a header.
        queue_byte(8'hFF, 1'b1);
        queue_frame(SOF_USE_A, 0, 1'b1, 0);
        queue_frame(SOF_USE_B, 3, 1'b0, 0);
        queue_frame(SOF_RANDOM, 0, 1'b1, -1);
      end

      start_bytes = bytes_queued;
      // Once: a full-length payload inside an over-long chunk.
      if (ph == 3)
        queue_frame(SOF_USE_B, 255, 1'b1, ChunkCap + 8 - crc_fc_pkg::HdrBytes - 255);

      while (bytes_queued - start_bytes < RandPerPhase) begin
        if ($urandom_range(99) < 80) begin
          r = $urandom_range(9);
          pick = (r < 4) ? SOF_USE_A : (r < 8) ? SOF_USE_B :
                 (r == 8) ? SOF_RANDOM : SOF_A_BROKEN;
          if ($urandom_range(59) == 0)
            len = $urandom_range(1) ? 255 : $urandom_range(13, 254);
          else
            len = $urandom_range(12);
          r = $urandom_range(9);
          if (r < 6) extra = 0;
          else if (r < 8) extra = $urandom_range(1, 6);
          else if (r == 8) extra = 0 - int'($urandom_range(1, 6 + len));
          else extra = $urandom_range(7, 40);
          queue_frame(pick, len, $urandom_range(7) != 0, extra);
        end else begin
          // Noise: a short chunk of random bytes.
          n = $urandom_range(1, 10);
          for (k = 0; k < n; k++) queue_byte(8'($urandom), k == n - 1);
        end
      end

      // Hold off until every byte is in and every beat is out, then let the
      // pipeline settle before touching registers.
      while (bytes_taken != bytes_queued || beats_due.size() != 0) @(posedge clk_i);
      repeat (SettleCycles) @(posedge clk_i);
    end

    if (miss_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
